// ----- design/lfucl_pkg.sv -----
`default_nettype none

package lfucl_pkg;

    // Field widths of one transfer on each channel.
    localparam int unsigned KEY_W = 32;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned USE_W = 32;
    localparam int unsigned CAP_W = 5;

    // Capacity after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Use counts stop at all ones.
    localparam logic [USE_W-1:0] USE_MAX = '1;

    // Access codes carried in the action field.
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    typedef struct packed {
        logic             action;
        logic [KEY_W-1:0] lookup_key;
        logic [VAL_W-1:0] write_value;
    } req_item_t;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
    } rsp_item_t;

    // Engine sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_RESULT,
        ST_SWEEP
    } state_t;

endpackage

`default_nettype wire

// ----- design/lfucl_store.sv -----
`default_nettype none

module lfucl_store #(
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned DATA_W = 8,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // One write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // One read port with registered data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- design/lfucl_engine.sv -----
`default_nettype none

module lfucl_engine #(
    parameter int unsigned ENTRIES = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire lfucl_pkg::req_item_t        req_item,
    input  wire logic [lfucl_pkg::CAP_W-1:0] cap,
    input  wire logic                        rsp_free,
    output logic                             rsp_load,
    output lfucl_pkg::rsp_item_t             rsp_item
);

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
    localparam int unsigned CMP_W = (CNT_W > lfucl_pkg::CAP_W) ? CNT_W : lfucl_pkg::CAP_W;
    localparam logic [CNT_W-1:0] END_CNT  = CNT_W'(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [CMP_W-1:0] ENT_CMP  = CMP_W'(ENTRIES);

    // One stored entry; recency is its rank among the valid entries.
    typedef struct packed {
        logic [lfucl_pkg::KEY_W-1:0] key;
        logic [lfucl_pkg::VAL_W-1:0] value;
        logic [lfucl_pkg::USE_W-1:0] uses;
        logic [IDX_W-1:0]            rec;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    lfucl_pkg::state_t    state_reg, state_next;
    lfucl_pkg::req_item_t item_reg, item_next;

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;

    // Results of the lookup pass.
    logic                        hit_reg, hit_next;
    logic [IDX_W-1:0]            slot_reg, slot_next;
    logic [lfucl_pkg::VAL_W-1:0] hval_reg, hval_next;
    logic [lfucl_pkg::USE_W-1:0] huses_reg, huses_next;
    logic [IDX_W-1:0]            hrec_reg, hrec_next;
    logic                        vfound_reg, vfound_next;
    logic [IDX_W-1:0]            vslot_reg, vslot_next;
    logic [lfucl_pkg::USE_W-1:0] vuses_reg, vuses_next;
    logic [IDX_W-1:0]            vrec_reg, vrec_next;
    logic                        ffound_reg, ffound_next;
    logic [IDX_W-1:0]            fslot_reg, fslot_next;

    // Plan for the update sweep.
    logic [IDX_W-1:0] tgt_reg, tgt_next;
    entry_t           wrec_reg, wrec_next;
    logic             gap_en_reg, gap_en_next;
    logic [IDX_W-1:0] gap_r_reg, gap_r_next;

    // Memory port signals.
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_entry;
    entry_t             cur;

    logic scanning;
    logic last_data;
    logic cur_valid;

    // Decision signals, meaningful in the result state.
    logic                        is_put;
    logic                        cap_zero;
    logic [CMP_W-1:0]            cap_ext;
    logic [CMP_W-1:0]            cap_eff;
    logic                        full;
    logic                        do_bump;
    logic                        do_insert;
    logic                        do_evict;
    logic                        do_write;
    logic [IDX_W-1:0]            ins_slot;
    logic [CNT_W-1:0]            occ_after;
    logic [lfucl_pkg::USE_W-1:0] uses_inc;

    lfucl_store #(
        .DEPTH  (ENTRIES),
        .DATA_W (ENTRY_W)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry)
    );

    assign cur       = entry_t'(rd_data);
    assign scanning  = (state_reg == lfucl_pkg::ST_LOOKUP) || (state_reg == lfucl_pkg::ST_SWEEP);
    assign last_data = rd_vld_reg && (rd_idx_reg == LAST_IDX);
    assign cur_valid = valid_reg[rd_idx_reg];
    assign rd_addr   = cnt_reg[IDX_W-1:0];

    // Decide what the access does once the lookup pass is complete.
    always_comb
    begin
        is_put    = (item_reg.action == lfucl_pkg::ACT_PUT);
        cap_zero  = (cap == '0);
        cap_ext   = CMP_W'(cap);
        cap_eff   = (cap_ext > ENT_CMP) ? ENT_CMP : cap_ext;
        full      = (CMP_W'(occ_reg) >= cap_eff);
        do_bump   = hit_reg && (!is_put || !cap_zero);
        do_insert = !hit_reg && is_put && !cap_zero;
        do_evict  = do_insert && full && vfound_reg;
        do_write  = do_bump || do_insert;
        // After an eviction the lowest free slot is the victim or an earlier hole.
        if (do_evict && (!ffound_reg || (vslot_reg < fslot_reg)))
        begin
            ins_slot = vslot_reg;
        end
        else
        begin
            ins_slot = fslot_reg;
        end
        occ_after = occ_reg - CNT_W'(do_evict);
        uses_inc  = (huses_reg == lfucl_pkg::USE_MAX) ? huses_reg : huses_reg + 1'b1;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lfucl_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = lfucl_pkg::ST_LOOKUP;
                end
            end
            lfucl_pkg::ST_LOOKUP:
            begin
                if (last_data)
                begin
                    state_next = lfucl_pkg::ST_RESULT;
                end
            end
            lfucl_pkg::ST_RESULT:
            begin
                if (rsp_free)
                begin
                    state_next = do_write ? lfucl_pkg::ST_SWEEP : lfucl_pkg::ST_IDLE;
                end
            end
            lfucl_pkg::ST_SWEEP:
            begin
                if (last_data)
                begin
                    state_next = lfucl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfucl_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        req_ready = 1'b0;
        rsp_load  = 1'b0;
        rd_en     = 1'b0;
        unique case (state_reg)
            lfucl_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            lfucl_pkg::ST_LOOKUP,
            lfucl_pkg::ST_SWEEP:
            begin
                rd_en = (cnt_reg != END_CNT);
            end
            lfucl_pkg::ST_RESULT:
            begin
                rsp_load = rsp_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    // Result of the access; a put never returns a value.
    always_comb
    begin
        rsp_item.hit        = hit_reg;
        rsp_item.read_value = (hit_reg && !is_put) ? hval_reg : '0;
    end

    // Sweep write-back: the target entry gets its new contents and, when a gap
    // is set, every valid entry ranked above the gap moves down by one.
    always_comb
    begin
        wr_addr  = rd_idx_reg;
        wr_en    = 1'b0;
        wr_entry = cur;
        if ((state_reg == lfucl_pkg::ST_SWEEP) && rd_vld_reg)
        begin
            if (rd_idx_reg == tgt_reg)
            begin
                wr_en    = 1'b1;
                wr_entry = wrec_reg;
            end
            else if (gap_en_reg && cur_valid && (cur.rec > gap_r_reg))
            begin
                wr_en        = 1'b1;
                wr_entry.rec = cur.rec - 1'b1;
            end
        end
    end

    // Read sequencing shared by both passes.
    always_comb
    begin
        cnt_next    = cnt_reg;
        rd_vld_next = 1'b0;
        rd_idx_next = rd_addr;
        if (scanning && (cnt_reg != END_CNT))
        begin
            cnt_next    = cnt_reg + 1'b1;
            rd_vld_next = 1'b1;
        end
        if ((state_reg == lfucl_pkg::ST_IDLE) || (state_reg == lfucl_pkg::ST_RESULT))
        begin
            cnt_next = '0;
        end
    end

    // Lookup pass: key match, eviction victim and first free slot.
    always_comb
    begin
        item_next   = item_reg;
        hit_next    = hit_reg;
        slot_next   = slot_reg;
        hval_next   = hval_reg;
        huses_next  = huses_reg;
        hrec_next   = hrec_reg;
        vfound_next = vfound_reg;
        vslot_next  = vslot_reg;
        vuses_next  = vuses_reg;
        vrec_next   = vrec_reg;
        ffound_next = ffound_reg;
        fslot_next  = fslot_reg;
        if ((state_reg == lfucl_pkg::ST_IDLE) && req_valid)
        begin
            item_next   = req_item;
            hit_next    = 1'b0;
            vfound_next = 1'b0;
            ffound_next = 1'b0;
        end
        else if ((state_reg == lfucl_pkg::ST_LOOKUP) && rd_vld_reg)
        begin
            if (cur_valid)
            begin
                if (!hit_reg && (cur.key == item_reg.lookup_key))
                begin
                    hit_next   = 1'b1;
                    slot_next  = rd_idx_reg;
                    hval_next  = cur.value;
                    huses_next = cur.uses;
                    hrec_next  = cur.rec;
                end
                if (!vfound_reg || (cur.uses < vuses_reg) ||
                    ((cur.uses == vuses_reg) && (cur.rec < vrec_reg)))
                begin
                    vfound_next = 1'b1;
                    vslot_next  = rd_idx_reg;
                    vuses_next  = cur.uses;
                    vrec_next   = cur.rec;
                end
            end
            else if (!ffound_reg)
            begin
                ffound_next = 1'b1;
                fslot_next  = rd_idx_reg;
            end
        end
    end

    // Commit the decision: valid bits, occupancy and the sweep plan.
    always_comb
    begin
        valid_next  = valid_reg;
        occ_next    = occ_reg;
        tgt_next    = tgt_reg;
        wrec_next   = wrec_reg;
        gap_en_next = gap_en_reg;
        gap_r_next  = gap_r_reg;
        if ((state_reg == lfucl_pkg::ST_RESULT) && rsp_free)
        begin
            if (do_bump)
            begin
                tgt_next       = slot_reg;
                gap_en_next    = 1'b1;
                gap_r_next     = hrec_reg;
                wrec_next.key  = item_reg.lookup_key;
                wrec_next.value = is_put ? item_reg.write_value : hval_reg;
                wrec_next.uses = uses_inc;
                wrec_next.rec  = IDX_W'(occ_reg - 1'b1);
            end
            else
            begin
                tgt_next        = ins_slot;
                gap_en_next     = do_evict;
                gap_r_next      = vrec_reg;
                wrec_next.key   = item_reg.lookup_key;
                wrec_next.value = item_reg.write_value;
                wrec_next.uses  = '0;
                wrec_next.rec   = IDX_W'(occ_after);
            end
            if (do_evict)
            begin
                valid_next[vslot_reg] = 1'b0;
            end
            if (do_insert)
            begin
                valid_next[ins_slot] = 1'b1;
                occ_next             = occ_after + 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lfucl_pkg::ST_IDLE;
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
            valid_reg  <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rd_vld_reg <= rd_vld_next;
            valid_reg  <= valid_next;
            occ_reg    <= occ_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        rd_idx_reg  <= rd_idx_next;
        hit_reg     <= hit_next;
        slot_reg    <= slot_next;
        hval_reg    <= hval_next;
        huses_reg   <= huses_next;
        hrec_reg    <= hrec_next;
        vfound_reg  <= vfound_next;
        vslot_reg   <= vslot_next;
        vuses_reg   <= vuses_next;
        vrec_reg    <= vrec_next;
        ffound_reg  <= ffound_next;
        fslot_reg   <= fslot_next;
        tgt_reg     <= tgt_next;
        wrec_reg    <= wrec_next;
        gap_en_reg  <= gap_en_next;
        gap_r_reg   <= gap_r_next;
    end

    // The occupancy count always agrees with the valid bits.
    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == occ_reg)
        else $error("occupancy does not match valid bits");

    // The store is only written during the update sweep.
    a_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == lfucl_pkg::ST_SWEEP))
        else $error("store written outside the sweep");

    // A read and a write never address the same entry in one cycle.
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write collide on one entry");

    // The last lookup read leads straight to the result state.
    a_lookup_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == lfucl_pkg::ST_LOOKUP) && last_data) |=>
            (state_reg == lfucl_pkg::ST_RESULT))
        else $error("lookup pass did not end in the result state");

endmodule

`default_nettype wire

// ----- design/lfu_cache_lru_tiebreak_top.sv -----
// LFU cache with LRU tie-break over an ENTRIES-deep single-port-read entry RAM.
// One access at a time: a lookup pass reads every entry on the one read port, the
// result loads the output register once free, then a get miss or a put ignored
// for zero capacity returns to idle and every other access runs an update sweep.
// Reset: all entries invalid, occupancy zero, capacity 16, no result pending.
`default_nettype none

module lfu_cache_lru_tiebreak_top #(
    parameter int unsigned ENTRIES = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire lfucl_pkg::req_item_t        req_item,
    output logic                             rsp_valid,
    input  wire logic                        rsp_ready,
    output lfucl_pkg::rsp_item_t             rsp_item,
    input  wire logic                        cfg_wr_en,
    input  wire logic [lfucl_pkg::CAP_W-1:0] cfg_wr_data
);

    logic [lfucl_pkg::CAP_W-1:0] cap_reg, cap_next;
    logic                        rsp_valid_reg, rsp_valid_next;
    lfucl_pkg::rsp_item_t        rsp_item_reg, rsp_item_next;

    logic                 rsp_free;
    logic                 rsp_load;
    lfucl_pkg::rsp_item_t eng_item;

    lfucl_engine #(
        .ENTRIES (ENTRIES)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .cap       (cap_reg),
        .rsp_free  (rsp_free),
        .rsp_load  (rsp_load),
        .rsp_item  (eng_item)
    );

    // The output register is free when empty or when its transfer completes.
    assign rsp_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        cap_next       = cfg_wr_en ? cfg_wr_data : cap_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_item_next  = rsp_item_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
            rsp_item_next  = eng_item;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= lfucl_pkg::CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_item_reg <= rsp_item_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

`default_nettype wire
